// ===== rtl/hla_pkg.sv =====
// hla_pkg: shared constants, types and trig table builder for the hough line accumulator
// no dependencies

`default_nettype none

package hla_pkg;

	localparam int BOX_SIDE_DEF       = 64;
	localparam int RADIUS_BINS_DEF    = 128;
	localparam int ANGLE_BINS_DEF     = 361;
	localparam int COUNT_WIDTH_DEF    = 16;
	localparam int TRIG_FRAC_BITS_DEF = 14;

	localparam int CMD_W  = 2;
	localparam int PIX_W  = 6;
	localparam int RBIN_W = 7;
	localparam int ANG_W  = 9;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_VOTE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_OUT_RANGE = 1'b1;

	localparam int ROM_ANGLES = 361;
	localparam int ROM_AW     = 9;
	localparam int TRIG_W_MAX = 22;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	typedef logic signed [TRIG_W_MAX-1:0] trig_word_t;
	typedef trig_word_t trig_rom_t [ROM_ANGLES];

	typedef struct packed {
		logic busy;
		logic hit;
	} radius_ctl_t;

	// sin of d degrees, d in 0..90, unsigned q30 by taylor series
	function automatic logic [63:0] sin_quarter_q30(input int unsigned d);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd272;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd342;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd420;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd506;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd600;
		sum  = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ONE_Q30)) begin
			sum = longint'(ONE_Q30);
		end
		return 64'(sum);
	endfunction

	function automatic trig_word_t sin_rom_value(input int unsigned d, input int frac);
		int unsigned q;
		int unsigned r;
		int unsigned base;
		int unsigned sh;
		logic [63:0] s;
		logic [63:0] mag;
		q    = (d / 90) & 3;
		r    = d % 90;
		base = ((q & 1) == 1) ? (90 - r) : r;
		s    = sin_quarter_q30(base);
		sh   = 30 - frac;
		mag  = (s + (64'd1 << (sh - 1))) >> sh;
		return ((q & 2) == 2) ? -trig_word_t'(mag) : trig_word_t'(mag);
	endfunction

	function automatic trig_rom_t build_trig_rom(input int frac, input bit cosine);
		trig_rom_t   rom;
		int unsigned a;
		for (a = 0; a < ROM_ANGLES; a++) begin
			rom[a] = sin_rom_value(cosine ? a + 90 : a, frac);
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hough_line_accumulator.sv =====
// hough_line_accumulator: a vote cell read steps through ST_RD_ADDR, ST_RD_MEM and ST_RD_DATA from accept to result
// a set pixel in the box is voted at all ANGLE_BINS angles, one angle per cycle,
// through the shared radius unit and the single read-modify-write port of the vote memory
// clear zero-fills all RADIUS_BINS * ANGLE_BINS cells (46208 by default), one cell per cycle
// after reset the same clearing pass runs with item_ready low
// one item at a time; a new item is taken once the previous result has been taken

`default_nettype none

module hough_line_accumulator #(
	parameter int BOX_SIDE       = hla_pkg::BOX_SIDE_DEF,
	parameter int RADIUS_BINS    = hla_pkg::RADIUS_BINS_DEF,
	parameter int ANGLE_BINS     = hla_pkg::ANGLE_BINS_DEF,
	parameter int COUNT_WIDTH    = hla_pkg::COUNT_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = hla_pkg::TRIG_FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_ready,
	input  wire logic [hla_pkg::CMD_W-1:0]   command,
	input  wire logic [hla_pkg::PIX_W-1:0]   pixel_x,
	input  wire logic [hla_pkg::PIX_W-1:0]   pixel_y,
	input  wire logic                        pixel_set,
	input  wire logic [hla_pkg::RBIN_W-1:0]  radius_bin,
	input  wire logic [hla_pkg::ANG_W-1:0]   angle_deg,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output logic      [COUNT_WIDTH-1:0]      cell_count,
	output logic                             status
);

	localparam int DEPTH = RADIUS_BINS * ANGLE_BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int ABW   = $clog2(ANGLE_BINS);
	localparam int RBW   = $clog2(RADIUS_BINS);
	localparam int CW    = COUNT_WIDTH;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_VOTE,
		ST_DRAIN,
		ST_RD_ADDR,
		ST_RD_MEM,
		ST_RD_DATA
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              sweep_q;
	logic                       clr_q;
	logic [ABW-1:0]             angle_q;
	logic [hla_pkg::PIX_W-1:0]  x_q, y_q;
	logic [RBW-1:0]             rb_q;
	logic [ABW-1:0]             ad_q;
	logic                       result_valid_q;
	logic [CW-1:0]              cell_count_q;
	logic                       status_q;

	hla_pkg::radius_ctl_t       rad_ctl;
	logic [RBW-1:0]             bin_s3;
	logic [ABW-1:0]             angle_s3;
	logic                       v_s4, v_s5;
	logic [AW-1:0]              addr_s4, addr_s5;
	logic [RBW-1:0]             bin_sel;
	logic [ABW-1:0]             angle_sel;
	logic [CW-1:0]              rd_data;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [CW-1:0]              wr_data;
	logic                       accept;
	logic                       in_box;
	logic                       rd_in_range;

	assign item_ready   = (state_q == ST_IDLE) && !result_valid_q;
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign cell_count   = cell_count_q;
	assign status       = status_q;

	assign in_box      = (int'(pixel_x) < BOX_SIDE) && (int'(pixel_y) < BOX_SIDE);
	assign rd_in_range = (int'(radius_bin) < RADIUS_BINS) && (int'(angle_deg) < ANGLE_BINS);

	hla_radius_unit #(
		.RADIUS_BINS    (RADIUS_BINS),
		.ANGLE_BINS     (ANGLE_BINS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.ABW            (ABW),
		.RBW            (RBW)
	) u_radius (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (state_q == ST_VOTE),
		.angle    (angle_q),
		.pixel_x  (x_q),
		.pixel_y  (y_q),
		.ctl      (rad_ctl),
		.bin_s3   (bin_s3),
		.angle_s3 (angle_s3)
	);

	// cell address: shared between vote pipeline and read
	assign bin_sel   = (state_q == ST_RD_ADDR) ? rb_q : bin_s3;
	assign angle_sel = (state_q == ST_RD_ADDR) ? ad_q : angle_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= rad_ctl.hit;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		addr_s4 <= AW'(bin_sel) * AW'(ANGLE_BINS) + AW'(angle_sel);
		addr_s5 <= addr_s4;
	end

	// saturating increment, or zero fill while sweeping
	always_comb begin
		if (state_q == ST_SWEEP) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
			wr_data = '0;
		end else begin
			wr_en   = v_s5 && (rd_data != {CW{1'b1}});
			wr_addr = addr_s5;
			wr_data = rd_data + CW'(1);
		end
	end

	hla_vote_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (addr_s4),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_SWEEP;
			sweep_q        <= '0;
			clr_q          <= 1'b0;
			angle_q        <= '0;
			result_valid_q <= 1'b0;
			cell_count_q   <= '0;
			status_q       <= hla_pkg::STATUS_OK;
			x_q            <= '0;
			y_q            <= '0;
			rb_q           <= '0;
			ad_q           <= '0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (sweep_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
						sweep_q <= '0;
						if (clr_q) begin
							clr_q          <= 1'b0;
							result_valid_q <= 1'b1;
							cell_count_q   <= '0;
							status_q       <= hla_pkg::STATUS_OK;
						end
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (command)
							hla_pkg::CMD_CLEAR: begin
								clr_q   <= 1'b1;
								sweep_q <= '0;
								state_q <= ST_SWEEP;
							end
							hla_pkg::CMD_VOTE: begin
								if (pixel_set && in_box) begin
									x_q     <= pixel_x;
									y_q     <= pixel_y;
									angle_q <= '0;
									state_q <= ST_VOTE;
								end else begin
									result_valid_q <= 1'b1;
									cell_count_q   <= '0;
									status_q       <= hla_pkg::STATUS_OK;
								end
							end
							hla_pkg::CMD_READ: begin
								if (rd_in_range) begin
									rb_q    <= RBW'(radius_bin);
									ad_q    <= ABW'(angle_deg);
									state_q <= ST_RD_ADDR;
								end else begin
									result_valid_q <= 1'b1;
									cell_count_q   <= '0;
									status_q       <= hla_pkg::STATUS_OUT_RANGE;
								end
							end
							default: begin
								result_valid_q <= 1'b1;
								cell_count_q   <= '0;
								status_q       <= hla_pkg::STATUS_OK;
							end
						endcase
					end
				end
				ST_VOTE: begin
					if (angle_q == ABW'(ANGLE_BINS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						angle_q <= angle_q + ABW'(1);
					end
				end
				ST_DRAIN: begin
					if (!rad_ctl.busy && !v_s4 && !v_s5) begin
						state_q        <= ST_IDLE;
						result_valid_q <= 1'b1;
						cell_count_q   <= '0;
						status_q       <= hla_pkg::STATUS_OK;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_MEM;
				end
				ST_RD_MEM: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					state_q        <= ST_IDLE;
					result_valid_q <= 1'b1;
					cell_count_q   <= rd_data;
					status_q       <= hla_pkg::STATUS_OK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hla_vote_mem.sv =====
// hla_vote_mem: vote counter memory, one write and one registered read per cycle
// no dependencies

`default_nettype none

module hla_vote_mem #(
	parameter int DEPTH = 46208,
	parameter int AW    = 16,
	parameter int CW    = 16
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [CW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [CW-1:0] rd_data
);

	logic [CW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/hla_radius_unit.sv =====
// hla_radius_unit: trig table read and radius computation, one angle per cycle
// depends on hla_pkg

`default_nettype none

module hla_radius_unit #(
	parameter int RADIUS_BINS    = hla_pkg::RADIUS_BINS_DEF,
	parameter int ANGLE_BINS     = hla_pkg::ANGLE_BINS_DEF,
	parameter int TRIG_FRAC_BITS = hla_pkg::TRIG_FRAC_BITS_DEF,
	parameter int ABW            = $clog2(ANGLE_BINS),
	parameter int RBW            = $clog2(RADIUS_BINS)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       issue,
	input  wire logic [ABW-1:0]             angle,
	input  wire logic [hla_pkg::PIX_W-1:0]  pixel_x,
	input  wire logic [hla_pkg::PIX_W-1:0]  pixel_y,
	output hla_pkg::radius_ctl_t            ctl,
	output logic      [RBW-1:0]             bin_s3,
	output logic      [ABW-1:0]             angle_s3
);

	localparam int TW  = TRIG_FRAC_BITS + 2;
	localparam int PW  = TW + hla_pkg::PIX_W + 1;
	localparam int SW  = PW + 1;
	localparam int RAW = hla_pkg::ROM_AW;

	localparam hla_pkg::trig_rom_t SIN_ROM = hla_pkg::build_trig_rom(TRIG_FRAC_BITS, 1'b0);
	localparam hla_pkg::trig_rom_t COS_ROM = hla_pkg::build_trig_rom(TRIG_FRAC_BITS, 1'b1);

	logic                 v_s1, v_s2, v_s3;
	logic                 hit_s3;
	logic [ABW-1:0]       angle_s1, angle_s2;
	logic signed [TW-1:0] cos_s1, sin_s1;
	logic signed [PW-1:0] xc_s2, ys_s2;
	logic signed [SW-1:0] sum;
	logic                 hit;

	assign sum = SW'(xc_s2) + SW'(ys_s2);
	assign hit = !sum[SW-1] && (sum != '0) &&
		(int'(sum[SW-1:TRIG_FRAC_BITS]) < RADIUS_BINS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			hit_s3 <= 1'b0;
		end else begin
			v_s1   <= issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			hit_s3 <= v_s2 && hit;
		end
	end

	always_ff @(posedge clk) begin
		cos_s1   <= COS_ROM[RAW'(angle)][TW-1:0];
		sin_s1   <= SIN_ROM[RAW'(angle)][TW-1:0];
		angle_s1 <= angle;
		xc_s2    <= PW'($signed({1'b0, pixel_x})) * PW'(cos_s1);
		ys_s2    <= PW'($signed({1'b0, pixel_y})) * PW'(sin_s1);
		angle_s2 <= angle_s1;
		bin_s3   <= sum[TRIG_FRAC_BITS+RBW-1:TRIG_FRAC_BITS];
		angle_s3 <= angle_s2;
	end

	assign ctl.busy = v_s1 || v_s2 || v_s3;
	assign ctl.hit  = hit_s3;

endmodule

`default_nettype wire
